// ----- rtl/assert_macros.svh -----
// assertion helpers shared by utsc_fifo and utsc_back
// ASSERT_ON expects clk_i and rst_ni in scope, ASSERT_ALWAYS only clk_i
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// checked on every clock, off while in reset
`define ASSERT_ON(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked on every clock, reset included
`define ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define ASSERT_ON(lbl, prop, msg)
`define ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// ----- rtl/utsc_pkg.sv -----
package utsc_pkg;

  localparam int unsigned CountWidth = 32;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned StatWidth  = 32;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [4:0]  stat_index;
    logic [31:0] stat_value;
    logic        last_stat;
  } out_item_t;

  typedef enum logic [3:0] {
    CLS_SPACE,
    CLS_TAB,
    CLS_NEWLINE,
    CLS_CR,
    CLS_OTHER_WS,
    CLS_LETTER,
    CLS_DIGIT,
    CLS_CJK,
    CLS_PUNCT_WORD,
    CLS_PUNCT,
    CLS_OTHER
  } char_class_e;

  typedef struct packed {
    char_class_e cls;
    logic        last;
  } char_item_t;

  typedef enum logic [4:0] {
    ST_CHARS, ST_NONSPACE, ST_NONWHITE, ST_SPACES, ST_TABS, ST_NEWLINES,
    ST_LETTERS, ST_DIGITS, ST_CJK, ST_PUNCT, ST_LINES, ST_NONEMPTY,
    ST_LONGEST, ST_SHORTEST, ST_LENSUM, ST_LINECOUNT, ST_WORDS
  } stat_idx_e;

  typedef enum logic [1:0] {
    B_RUN,
    B_CLOSE,
    B_FIX,
    B_REPORT
  } back_state_e;

  // sequence length announced by a lead byte
  function automatic logic [2:0] lead_len(input logic [7:0] c);
    logic [2:0] n;
    n = 3'd1;
    if ((c & 8'hE0) == 8'hC0) n = 3'd2;
    else if ((c & 8'hF0) == 8'hE0) n = 3'd3;
    else if ((c & 8'hF8) == 8'hF0) n = 3'd4;
    return n;
  endfunction

  // character class of a code point
  function automatic char_class_e classify(input logic [20:0] cp);
    char_class_e c;
    if (cp == 21'h20) c = CLS_SPACE;
    else if (cp == 21'h09) c = CLS_TAB;
    else if (cp == 21'h0A) c = CLS_NEWLINE;
    else if (cp == 21'h0D) c = CLS_CR;
    else if (cp == 21'h0C || cp == 21'h0B) c = CLS_OTHER_WS;
    else if ((cp >= 21'h41 && cp <= 21'h5A) || (cp >= 21'h61 && cp <= 21'h7A))
      c = CLS_LETTER;
    else if (cp >= 21'h30 && cp <= 21'h39) c = CLS_DIGIT;
    else if ((cp >= 21'h4E00 && cp <= 21'h9FFF) || (cp >= 21'h3400 && cp <= 21'h4DBF) ||
             (cp >= 21'h20000 && cp <= 21'h2A6DF) ||
             (cp >= 21'h2A700 && cp <= 21'h2CEAF))
      c = CLS_CJK;
    else if (cp == 21'h5F || cp == 21'h27) c = CLS_PUNCT_WORD;
    else if ((cp >= 21'h21 && cp <= 21'h2F) || (cp >= 21'h3A && cp <= 21'h40) ||
             (cp >= 21'h5B && cp <= 21'h60) || (cp >= 21'h7B && cp <= 21'h7E))
      c = CLS_PUNCT;
    else c = CLS_OTHER;
    return c;
  endfunction

endpackage

// ----- rtl/utf8_text_statistics_counter_core.sv -----
// Text statistics counter. Feed one text byte per transaction; with utf8_mode set,
// multi-byte sequences are decoded and counted as one character. Bytes are taken
// at one per cycle while the queue has room and no flush runs. The byte marked
// end_of_text closes the text: a truncated sequence still open is flushed into
// the queue, the statistics unit applies the closing line rules, and seventeen
// result transactions follow, index 0 to 16, the last one flagged by last_stat.
// Input keeps flowing into the four-entry character queue during the report and
// stalls once it is full. Counters saturate; the unit is ready for the next text
// right after the final result transaction. Write utf8_mode only while idle.
module utf8_text_statistics_counter_core import utsc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidth
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic      cfg_data_i,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  logic       mode_q;
  logic       push, full, pop, empty;
  char_item_t push_data, pop_data;

  // mode register
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      mode_q <= cfg_data_i;
    end
  end

  utsc_front u_front (
    .clk_i, .rst_ni,
    .utf8_mode_i (mode_q),
    .in_valid_i, .in_stall_o, .in_data_i,
    .full_i      (full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  utsc_fifo u_fifo (
    .clk_i, .rst_ni,
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .empty_o     (empty),
    .pop_data_o  (pop_data)
  );

  utsc_back #(.COUNT_WIDTH(COUNT_WIDTH)) u_back (
    .clk_i, .rst_ni,
    .empty_i     (empty),
    .item_i      (pop_data),
    .pop_o       (pop),
    .out_valid_o, .out_stall_i, .out_data_o
  );

endmodule

// ----- rtl/utsc_front.sv -----
module utsc_front import utsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       utf8_mode_i,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  in_item_t   in_data_i,
  input  logic       full_i,
  output logic       push_o,
  output char_item_t push_data_o
);

  logic [7:0]  pb_q [3];
  logic [7:0]  pb_d [3];
  logic [1:0]  pcnt_q, pcnt_d;
  logic [2:0]  exp_q, exp_d;
  logic        flush_q, flush_d;
  logic [1:0]  fidx_q, fidx_d;
  logic [20:0] cp;
  logic        last;
  logic        accept;
  logic [7:0]  b;

  // byte decode and end-of-text flush sequencing
  always_comb begin
    pb_d    = pb_q;
    pcnt_d  = pcnt_q;
    exp_d   = exp_q;
    flush_d = flush_q;
    fidx_d  = fidx_q;
    push_o  = 1'b0;
    cp      = '0;
    last    = 1'b0;
    b       = in_data_i.text_byte;
    in_stall_o = flush_q || full_i;
    accept  = in_valid_i && !in_stall_o;
    if (flush_q) begin
      case (fidx_q)
        2'd0: begin
          cp   = {13'd0, pb_q[0]};
          last = (pcnt_q == 2'd1);
        end
        2'd1: begin
          if (pcnt_q == 2'd3 && lead_len(pb_q[1]) == 3'd2) begin
            cp   = {10'd0, pb_q[1][4:0], pb_q[2][5:0]};
            last = 1'b1;
          end else begin
            cp   = {13'd0, pb_q[1]};
            last = (pcnt_q == 2'd2);
          end
        end
        default: begin
          cp   = {13'd0, pb_q[2]};
          last = 1'b1;
        end
      endcase
      if (!full_i) begin
        push_o = 1'b1;
        fidx_d = fidx_q + 2'd1;
        if (last) begin
          flush_d = 1'b0;
          pcnt_d  = '0;
          exp_d   = '0;
          fidx_d  = '0;
        end
      end
    end else if (accept) begin
      if (pcnt_q != 2'd0) begin
        if ((3'(pcnt_q) + 3'd1) >= exp_q) begin
          case (exp_q)
            3'd2:    cp = {10'd0, pb_q[0][4:0], b[5:0]};
            3'd3:    cp = {5'd0, pb_q[0][3:0], pb_q[1][5:0], b[5:0]};
            default: cp = {pb_q[0][2:0], pb_q[1][5:0], pb_q[2][5:0], b[5:0]};
          endcase
          push_o = 1'b1;
          pcnt_d = '0;
          exp_d  = '0;
        end else begin
          pb_d[pcnt_q] = b;
          pcnt_d       = pcnt_q + 2'd1;
        end
      end else if (utf8_mode_i && lead_len(b) > 3'd1) begin
        pb_d[0] = b;
        pcnt_d  = 2'd1;
        exp_d   = lead_len(b);
      end else begin
        cp     = {13'd0, b};
        push_o = 1'b1;
      end
      if (in_data_i.end_of_text) begin
        if (pcnt_d != 2'd0) begin
          flush_d = 1'b1;
          fidx_d  = '0;
        end else begin
          last = 1'b1;
        end
      end
    end
    push_data_o.cls  = classify(cp);
    push_data_o.last = last;
  end

  // pending sequence state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcnt_q  <= '0;
      exp_q   <= '0;
      flush_q <= 1'b0;
      fidx_q  <= '0;
      pb_q    <= '{default: '0};
    end else begin
      pcnt_q  <= pcnt_d;
      exp_q   <= exp_d;
      flush_q <= flush_d;
      fidx_q  <= fidx_d;
      pb_q    <= pb_d;
    end
  end

endmodule

// ----- rtl/utsc_fifo.sv -----
`include "assert_macros.svh"
module utsc_fifo import utsc_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       push_i,
  input  char_item_t push_data_i,
  output logic       full_o,
  input  logic       pop_i,
  output logic       empty_o,
  output char_item_t pop_data_o
);

  char_item_t             mem_q [QueueDepth];
  logic [QueuePtrW-1:0]   wr_q, rd_q;
  logic [QueuePtrW:0]     cnt_q;

  assign full_o     = (cnt_q == (QueuePtrW+1)'(QueueDepth));
  assign empty_o    = (cnt_q == '0);
  assign pop_data_o = mem_q[rd_q];

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      if (push_i && !pop_i) cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  `ASSERT_ON(a_no_overflow, push_i |-> !full_o, "push into full queue")
  `ASSERT_ON(a_no_underflow, pop_i |-> !empty_o, "pop from empty queue")
  `ASSERT_ON(a_level, cnt_q <= (QueuePtrW+1)'(QueueDepth), "queue level out of range")

endmodule

// ----- rtl/utsc_back.sv -----
`include "assert_macros.svh"
module utsc_back import utsc_pkg::*; #(
  parameter int unsigned COUNT_WIDTH = CountWidth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       empty_i,
  input  char_item_t item_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output out_item_t  out_data_o
);

  typedef logic [COUNT_WIDTH-1:0] cnt_t;

  function automatic cnt_t inc(input cnt_t v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

  function automatic cnt_t sat_add(input cnt_t a, input cnt_t c);
    logic [COUNT_WIDTH:0] s;
    s = {1'b0, a} + {1'b0, c};
    return s[COUNT_WIDTH] ? '1 : s[COUNT_WIDTH-1:0];
  endfunction

  function automatic logic [StatWidth-1:0] sat32(input cnt_t v);
    logic [63:0] e;
    e = 64'(v);
    return (|e[63:32]) ? '1 : e[31:0];
  endfunction

  back_state_e st_q, st_d;
  stat_idx_e   idx_q, idx_d;
  cnt_t chars_q, chars_d, nonspace_q, nonspace_d, nonwhite_q, nonwhite_d;
  cnt_t spaces_q, spaces_d, tabs_q, tabs_d, newlines_q, newlines_d;
  cnt_t letters_q, letters_d, digits_q, digits_d, cjk_q, cjk_d;
  cnt_t punct_q, punct_d, lines_q, lines_d, nonempty_q, nonempty_d;
  cnt_t longest_q, longest_d, shortest_q, shortest_d, sum_q, sum_d;
  cnt_t cl_q, cl_d, ll_q, ll_d, words_q, words_d;
  logic hc_q, hc_d, wo_q, wo_d, lwn_q, lwn_d;
  logic do_record, end_word, is_ws;
  cnt_t out_val;

  // character update, closing rules and report sequencing
  always_comb begin
    st_d = st_q;  idx_d = idx_q;
    chars_d = chars_q;  nonspace_d = nonspace_q;  nonwhite_d = nonwhite_q;
    spaces_d = spaces_q;  tabs_d = tabs_q;  newlines_d = newlines_q;
    letters_d = letters_q;  digits_d = digits_q;  cjk_d = cjk_q;
    punct_d = punct_q;  lines_d = lines_q;  nonempty_d = nonempty_q;
    longest_d = longest_q;  shortest_d = shortest_q;  sum_d = sum_q;
    cl_d = cl_q;  ll_d = ll_q;  words_d = words_q;
    hc_d = hc_q;  wo_d = wo_q;  lwn_d = lwn_q;
    do_record = 1'b0;
    end_word  = 1'b0;
    pop_o     = 1'b0;
    is_ws = (item_i.cls == CLS_SPACE) || (item_i.cls == CLS_TAB) ||
            (item_i.cls == CLS_NEWLINE) || (item_i.cls == CLS_CR) ||
            (item_i.cls == CLS_OTHER_WS);
    case (st_q)
      B_RUN: begin
        if (!empty_i) begin
          pop_o   = 1'b1;
          chars_d = inc(chars_q);
          if (!is_ws) nonwhite_d = inc(nonwhite_q);
          if (item_i.cls != CLS_SPACE) nonspace_d = inc(nonspace_q);
          lwn_d = (item_i.cls == CLS_NEWLINE);
          case (item_i.cls)
            CLS_SPACE: begin
              spaces_d = inc(spaces_q);
              end_word = 1'b1;
            end
            CLS_TAB: begin
              tabs_d   = inc(tabs_q);
              end_word = 1'b1;
            end
            CLS_NEWLINE: begin
              newlines_d = inc(newlines_q);
              lines_d    = inc(lines_q);
              if (hc_q) begin
                nonempty_d = inc(nonempty_q);
                hc_d       = 1'b0;
              end
              do_record = (cl_q != '0) || (ll_q != '0);
              end_word  = 1'b1;
            end
            CLS_CR: begin
            end
            CLS_OTHER_WS: begin
              end_word = 1'b1;
            end
            CLS_LETTER: begin
              letters_d = inc(letters_q);
              hc_d = 1'b1;  ll_d = inc(ll_q);  wo_d = 1'b1;
            end
            CLS_DIGIT: begin
              digits_d = inc(digits_q);
              hc_d = 1'b1;  ll_d = inc(ll_q);  wo_d = 1'b1;
            end
            CLS_CJK: begin
              cjk_d = inc(cjk_q);
              hc_d = 1'b1;  ll_d = inc(ll_q);  end_word = 1'b1;
            end
            CLS_PUNCT_WORD: begin
              punct_d = inc(punct_q);
              hc_d = 1'b1;  ll_d = inc(ll_q);  wo_d = 1'b1;
            end
            CLS_PUNCT: begin
              punct_d = inc(punct_q);
              hc_d = 1'b1;  ll_d = inc(ll_q);  end_word = 1'b1;
            end
            default: begin
              hc_d = 1'b1;  ll_d = inc(ll_q);  end_word = 1'b1;
            end
          endcase
          if (item_i.cls == CLS_NEWLINE) ll_d = '0;
          if (item_i.last) st_d = B_CLOSE;
        end
      end
      B_CLOSE: begin
        end_word = 1'b1;
        if (!lwn_q) begin
          lines_d = inc(lines_q);
          if (hc_q) nonempty_d = inc(nonempty_q);
          do_record = (ll_q != '0) || (cl_q != '0);
        end
        st_d = B_FIX;
      end
      B_FIX: begin
        if (cl_q == '0) begin
          cl_d = cnt_t'(1);
          sum_d = chars_q;  longest_d = chars_q;  shortest_d = chars_q;
        end
        idx_d = ST_CHARS;
        st_d  = B_REPORT;
      end
      default: begin
        if (!out_stall_i) begin
          if (idx_q == ST_WORDS) begin
            st_d = B_RUN;  idx_d = ST_CHARS;
            chars_d = '0;  nonspace_d = '0;  nonwhite_d = '0;
            spaces_d = '0;  tabs_d = '0;  newlines_d = '0;
            letters_d = '0;  digits_d = '0;  cjk_d = '0;
            punct_d = '0;  lines_d = '0;  nonempty_d = '0;
            longest_d = '0;  shortest_d = '1;  sum_d = '0;
            cl_d = '0;  ll_d = '0;  words_d = '0;
            hc_d = 1'b0;  wo_d = 1'b0;  lwn_d = 1'b0;
          end else begin
            idx_d = stat_idx_e'(idx_q + 5'd1);
          end
        end
      end
    endcase
    // word close
    if (end_word && wo_q) begin
      words_d = inc(words_q);
      wo_d    = 1'b0;
    end
    // line record
    if (do_record) begin
      if (ll_q > longest_q)  longest_d  = ll_q;
      if (ll_q < shortest_q) shortest_d = ll_q;
      sum_d = sat_add(sum_q, ll_q);
      cl_d  = inc(cl_q);
    end
  end

  // report selection
  always_comb begin
    case (idx_q)
      ST_CHARS:     out_val = chars_q;
      ST_NONSPACE:  out_val = nonspace_q;
      ST_NONWHITE:  out_val = nonwhite_q;
      ST_SPACES:    out_val = spaces_q;
      ST_TABS:      out_val = tabs_q;
      ST_NEWLINES:  out_val = newlines_q;
      ST_LETTERS:   out_val = letters_q;
      ST_DIGITS:    out_val = digits_q;
      ST_CJK:       out_val = cjk_q;
      ST_PUNCT:     out_val = punct_q;
      ST_LINES:     out_val = lines_q;
      ST_NONEMPTY:  out_val = nonempty_q;
      ST_LONGEST:   out_val = longest_q;
      ST_SHORTEST:  out_val = shortest_q;
      ST_LENSUM:    out_val = sum_q;
      ST_LINECOUNT: out_val = cl_q;
      ST_WORDS:     out_val = words_q;
      default:      out_val = '0;
    endcase
  end

  assign out_valid_o           = (st_q == B_REPORT);
  assign out_data_o.stat_index = idx_q;
  assign out_data_o.stat_value = sat32(out_val);
  assign out_data_o.last_stat  = (idx_q == ST_WORDS);

  // statistics registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= B_RUN;  idx_q <= ST_CHARS;
      chars_q <= '0;  nonspace_q <= '0;  nonwhite_q <= '0;
      spaces_q <= '0;  tabs_q <= '0;  newlines_q <= '0;
      letters_q <= '0;  digits_q <= '0;  cjk_q <= '0;
      punct_q <= '0;  lines_q <= '0;  nonempty_q <= '0;
      longest_q <= '0;  shortest_q <= '1;  sum_q <= '0;
      cl_q <= '0;  ll_q <= '0;  words_q <= '0;
      hc_q <= 1'b0;  wo_q <= 1'b0;  lwn_q <= 1'b0;
    end else begin
      st_q <= st_d;  idx_q <= idx_d;
      chars_q <= chars_d;  nonspace_q <= nonspace_d;  nonwhite_q <= nonwhite_d;
      spaces_q <= spaces_d;  tabs_q <= tabs_d;  newlines_q <= newlines_d;
      letters_q <= letters_d;  digits_q <= digits_d;  cjk_q <= cjk_d;
      punct_q <= punct_d;  lines_q <= lines_d;  nonempty_q <= nonempty_d;
      longest_q <= longest_d;  shortest_q <= shortest_d;  sum_q <= sum_d;
      cl_q <= cl_d;  ll_q <= ll_d;  words_q <= words_d;
      hc_q <= hc_d;  wo_q <= wo_d;  lwn_q <= lwn_d;
    end
  end

  `ASSERT_ON(a_idx_idle, (st_q == B_RUN) |-> (idx_q == ST_CHARS), "report index not parked")
  `ASSERT_ON(a_no_lines_no_len, (st_q == B_RUN && cl_q == '0) |-> (sum_q == '0 && longest_q == '0), "line figures without a counted line")
  `ASSERT_ON(a_no_pop_report, (st_q != B_RUN) |-> !pop_o, "queue popped while closing or reporting")

endmodule
